/* src/stst_pkg.sv */
// shared types, constants and keyword tables for the source tokenizer
// no dependencies; stst_symtab, the top module and the testbench import this package
package stst_pkg;

    // default sizes of the symbol table, the name store and the name buffer
    localparam int TABLE_ENTRIES_DEF    = 128;
    localparam int NAME_STORE_BYTES_DEF = 1024;
    localparam int NAME_MAX_DEF         = 128;

    localparam int TOKEN_W = 9;
    localparam int VALUE_W = 32;
    localparam int LINE_W  = 16;
    localparam int NUM_W   = 31;

    localparam logic [TOKEN_W-1:0] TOK_NUM  = 9'd256;
    localparam logic [TOKEN_W-1:0] TOK_ID   = 9'd259;
    localparam logic [TOKEN_W-1:0] TOK_DONE = 9'd260;
    localparam logic [TOKEN_W-1:0] TOK_NONE = 9'd0;
    localparam logic [VALUE_W-1:0] VALUE_NONE = 32'hFFFF_FFFF;
    localparam logic [NUM_W-1:0]   NUM_LIMIT  = 31'h7FFF_FFFF;
    localparam logic [LINE_W-1:0]  LINE_MAX   = 16'hFFFF;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NAME_LONG  = 2'd1;
    localparam logic [1:0] ERR_TABLE_FULL = 2'd2;
    localparam logic [1:0] ERR_STORE_FULL = 2'd3;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_ZERO    = 8'h30;

    // preloaded keywords, each followed by one separator byte
    localparam int KW_COUNT = 22;
    localparam int KW_BYTES = 123;
    localparam int KW_CNT_W = 7;
    localparam logic [KW_BYTES*8-1:0] KW_TEXT =
        {"div mod program infix postfix begin end input output CONST VAR ",
         "integer real char boolean if then while do writeln else not "};
    localparam logic [TOKEN_W-1:0] KW_CODE [KW_COUNT] = '{
        9'd257, 9'd258, 9'd261, 9'd262, 9'd263, 9'd264, 9'd265, 9'd266,
        9'd267, 9'd268, 9'd269, 9'd271, 9'd272, 9'd273, 9'd274, 9'd275,
        9'd276, 9'd277, 9'd278, 9'd279, 9'd280, 9'd284};
    localparam logic [6:0] KW_START [KW_COUNT] = '{
        7'd0, 7'd4, 7'd8, 7'd16, 7'd22, 7'd30, 7'd36, 7'd40, 7'd46, 7'd53, 7'd59,
        7'd63, 7'd71, 7'd76, 7'd81, 7'd89, 7'd92, 7'd97, 7'd103, 7'd106, 7'd114,
        7'd119};
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd3, 3'd7, 3'd5, 3'd7, 3'd5, 3'd3, 3'd5, 3'd6, 3'd5, 3'd3,
        3'd7, 3'd4, 3'd4, 3'd7, 3'd2, 3'd4, 3'd5, 3'd2, 3'd7, 3'd4, 3'd3};

    function automatic logic [7:0] kw_byte(input logic [KW_CNT_W-1:0] i);
        return KW_TEXT[(KW_BYTES - 1 - int'(i)) * 8 +: 8];
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } src_word_t;

    typedef struct packed {
        logic [TOKEN_W-1:0]        token;
        logic signed [VALUE_W-1:0] token_value;
        logic [LINE_W-1:0]         line;
        logic [1:0]                error_kind;
        logic                      last_of_run;
    } tok_word_t;

    // lexer to symbol table
    typedef struct packed {
        logic lookup_go;
        logic char_we;
    } sym_ctl_t;

    // symbol table to lexer
    typedef struct packed {
        logic               ready;
        logic               idle;
        logic               done;
        logic [1:0]         err;
        logic [TOKEN_W-1:0] token;
    } sym_rsp_t;

    typedef enum logic [2:0] {
        M_IDLE, M_NUMBER, M_NAME, M_COMMENT, M_HALT
    } lex_mode_t;

    typedef enum logic [2:0] {
        LX_IDLE, LX_STEP, LX_FRESH, LX_LOOK, LX_WAIT, LX_EMIT
    } lex_state_t;

    typedef enum logic [3:0] {
        SY_INIT, SY_IDLE, SY_ENT, SY_ECHK, SY_BRD, SY_BCHK, SY_MISS, SY_IRD,
        SY_IWR, SY_DONE
    } sym_state_t;

endpackage

/* src/stst_ram.sv */
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module stst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/stst_symtab.sv */
// symbol table: entry ram, name store ram, name buffer ram and the
// preload, lookup and insert sequencer; uses stst_pkg and stst_ram
module stst_symtab
    import stst_pkg::*;
#(
    parameter int TABLE_ENTRIES    = TABLE_ENTRIES_DEF,
    parameter int NAME_STORE_BYTES = NAME_STORE_BYTES_DEF,
    parameter int NAME_MAX         = NAME_MAX_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sym_ctl_t                           ctl,
    input  logic [$clog2(NAME_MAX+1)-1:0]      name_len,
    input  logic [$clog2(NAME_MAX)-1:0]        char_addr,
    input  logic [7:0]                         name_char,
    output sym_rsp_t                           rsp,
    output logic [$clog2(TABLE_ENTRIES)-1:0]   idx
);

    localparam int ENT_W   = $clog2(TABLE_ENTRIES);
    localparam int STORE_W = $clog2(NAME_STORE_BYTES);
    localparam int BU_W    = $clog2(NAME_STORE_BYTES + 1);
    localparam int NB_W    = $clog2(NAME_MAX);
    localparam int LEN_W   = $clog2(NAME_MAX + 1);
    localparam int SUM_W   = ((BU_W > LEN_W) ? BU_W : LEN_W) + 1;
    localparam int ENTRY_W = TOKEN_W + STORE_W + LEN_W;

    sym_state_t state_reg, state_next;
    logic [ENT_W-1:0]    p_reg, p_next;
    logic [LEN_W-1:0]    k_reg, k_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [STORE_W-1:0]  start_reg, start_next;
    logic [TOKEN_W-1:0]  etok_reg, etok_next;
    logic [KW_CNT_W-1:0] init_reg, init_next;
    logic [ENT_W-1:0]    entry_count_reg, entry_count_next;
    logic [BU_W-1:0]     bytes_used_reg, bytes_used_next;
    logic [1:0]          err_reg, err_next;
    logic [TOKEN_W-1:0]  tok_reg, tok_next;
    logic [ENT_W-1:0]    idx_reg, idx_next;

    logic               ent_we;
    logic [ENT_W-1:0]   ent_waddr;
    logic [ENTRY_W-1:0] ent_wdata, ent_rdata;
    logic               st_we;
    logic [STORE_W-1:0] st_waddr, st_raddr;
    logic [7:0]         st_wdata, st_rdata;
    logic [7:0]         nb_rdata;

    logic [TOKEN_W-1:0] rd_tok;
    logic [STORE_W-1:0] rd_start;
    logic [LEN_W-1:0]   rd_len;
    logic [SUM_W-1:0]   cmp_sum, ins_sum, fill_sum;
    logic               table_full, store_full, last_byte;
    logic [ENT_W:0]     count_plus;

    assign {rd_tok, rd_start, rd_len} = ent_rdata;
    assign cmp_sum    = SUM_W'(start_reg) + SUM_W'(k_reg);
    assign ins_sum    = SUM_W'(bytes_used_reg) + SUM_W'(k_reg);
    assign fill_sum   = SUM_W'(bytes_used_reg) + SUM_W'(len_reg);
    assign st_raddr   = cmp_sum[STORE_W-1:0];
    assign count_plus = (ENT_W+1)'(entry_count_reg) + (ENT_W+1)'(1);
    assign table_full = count_plus >= (ENT_W+1)'(TABLE_ENTRIES);
    assign store_full = fill_sum >= SUM_W'(NAME_STORE_BYTES);
    assign last_byte  = (k_reg + LEN_W'(1)) == len_reg;

    stst_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
        .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
        .raddr(p_reg), .rdata(ent_rdata)
    );

    stst_ram #(.WIDTH(8), .DEPTH(NAME_STORE_BYTES)) u_store_ram (
        .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );

    stst_ram #(.WIDTH(8), .DEPTH(NAME_MAX)) u_nbuf_ram (
        .clk(clk), .we(ctl.char_we), .waddr(char_addr), .wdata(name_char),
        .raddr(k_reg[NB_W-1:0]), .rdata(nb_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SY_INIT:
            begin
                if (init_reg == KW_CNT_W'(KW_BYTES - 1))
                begin
                    state_next = SY_IDLE;
                end
            end
            SY_IDLE:
            begin
                if (ctl.lookup_go)
                begin
                    state_next = SY_ENT;
                end
            end
            SY_ENT:
            begin
                state_next = (p_reg == '0) ? SY_MISS : SY_ECHK;
            end
            SY_ECHK:
            begin
                state_next = (rd_len == len_reg) ? SY_BRD : SY_ENT;
            end
            SY_BRD:
            begin
                state_next = SY_BCHK;
            end
            SY_BCHK:
            begin
                if (st_rdata != nb_rdata)
                begin
                    state_next = SY_ENT;
                end
                else
                begin
                    state_next = last_byte ? SY_DONE : SY_BRD;
                end
            end
            SY_MISS:
            begin
                state_next = (table_full || store_full) ? SY_DONE : SY_IRD;
            end
            SY_IRD:
            begin
                state_next = SY_IWR;
            end
            SY_IWR:
            begin
                state_next = last_byte ? SY_DONE : SY_IRD;
            end
            SY_DONE:
            begin
                state_next = SY_IDLE;
            end
            default:
            begin
                state_next = SY_IDLE;
            end
        endcase
    end

    // datapath and ram controls
    always_comb
    begin
        p_next           = p_reg;
        k_next           = k_reg;
        len_next         = len_reg;
        start_next       = start_reg;
        etok_next        = etok_reg;
        init_next        = init_reg;
        entry_count_next = entry_count_reg;
        bytes_used_next  = bytes_used_reg;
        err_next         = err_reg;
        tok_next         = tok_reg;
        idx_next         = idx_reg;
        ent_we           = 1'b0;
        ent_waddr        = '0;
        ent_wdata        = '0;
        st_we            = 1'b0;
        st_waddr         = ins_sum[STORE_W-1:0];
        st_wdata         = nb_rdata;
        case (state_reg)
            SY_INIT:
            begin
                // keyword bytes, and one entry a cycle for the first ones
                st_we     = 1'b1;
                st_waddr  = STORE_W'(init_reg);
                st_wdata  = kw_byte(init_reg);
                init_next = init_reg + KW_CNT_W'(1);
                if (init_reg < KW_CNT_W'(KW_COUNT))
                begin
                    ent_we    = 1'b1;
                    ent_waddr = ENT_W'(init_reg) + ENT_W'(1);
                    ent_wdata = {KW_CODE[init_reg[4:0]],
                                 STORE_W'(KW_START[init_reg[4:0]]),
                                 LEN_W'(KW_LEN[init_reg[4:0]])};
                end
            end
            SY_IDLE:
            begin
                p_next   = entry_count_reg;
                len_next = name_len;
            end
            SY_ECHK:
            begin
                // length match starts the byte compare, else next older entry
                start_next = rd_start;
                etok_next  = rd_tok;
                k_next     = '0;
                if (rd_len != len_reg)
                begin
                    p_next = p_reg - ENT_W'(1);
                end
            end
            SY_BCHK:
            begin
                if (st_rdata != nb_rdata)
                begin
                    p_next = p_reg - ENT_W'(1);
                end
                else if (last_byte)
                begin
                    err_next = ERR_NONE;
                    tok_next = etok_reg;
                    idx_next = p_reg;
                end
                else
                begin
                    k_next = k_reg + LEN_W'(1);
                end
            end
            SY_MISS:
            begin
                k_next   = '0;
                tok_next = TOK_NONE;
                if (table_full)
                begin
                    err_next = ERR_TABLE_FULL;
                end
                else if (store_full)
                begin
                    err_next = ERR_STORE_FULL;
                end
            end
            SY_IWR:
            begin
                // copy one name byte into the store
                st_we = 1'b1;
                if (last_byte)
                begin
                    ent_we           = 1'b1;
                    ent_waddr        = count_plus[ENT_W-1:0];
                    ent_wdata        = {TOK_ID, bytes_used_reg[STORE_W-1:0], len_reg};
                    entry_count_next = count_plus[ENT_W-1:0];
                    bytes_used_next  = BU_W'(fill_sum + SUM_W'(1));
                    err_next         = ERR_NONE;
                    tok_next         = TOK_ID;
                    idx_next         = count_plus[ENT_W-1:0];
                end
                else
                begin
                    k_next = k_reg + LEN_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= SY_INIT;
            init_reg        <= '0;
            entry_count_reg <= ENT_W'(KW_COUNT);
            bytes_used_reg  <= BU_W'(KW_BYTES);
        end
        else
        begin
            state_reg       <= state_next;
            init_reg        <= init_next;
            entry_count_reg <= entry_count_next;
            bytes_used_reg  <= bytes_used_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        k_reg     <= k_next;
        len_reg   <= len_next;
        start_reg <= start_next;
        etok_reg  <= etok_next;
        err_reg   <= err_next;
        tok_reg   <= tok_next;
        idx_reg   <= idx_next;
    end

    // response
    always_comb
    begin
        rsp.ready = (state_reg != SY_INIT);
        rsp.idle  = (state_reg == SY_IDLE);
        rsp.done  = (state_reg == SY_DONE);
        rsp.err   = err_reg;
        rsp.token = tok_reg;
        idx       = idx_reg;
    end

    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == SY_DONE |=> state_reg == SY_IDLE)
        else $error("symbol table response held longer than one cycle");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg >= $past(entry_count_reg))
        else $error("entry count went down");

    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bytes_used_reg <= BU_W'(NAME_STORE_BYTES))
        else $error("name store overrun");

endmodule

/* src/source_tokenizer_symbol_table.sv */
// Source tokenizer with a keyword-preloaded symbol table. One character word
// is taken per input handshake and zero, one or two token words come out.
// After reset the block writes the keyword spellings and the 22 keyword
// entries into its memories and stalls its input meanwhile. A character is
// captured while idle and handled in the step state. One that is skipped or
// starts a number, a name or a comment passes the fresh state as well, and one
// that gives a token waits in the emit state until the output register can
// take it. Ending a number emits the number word before the fresh state. A
// name end runs the symbol table sequencer over the entry ram, newest entry
// first: it reads each entry and checks its length, compares entries of equal
// length byte by byte and, on a miss with room left, copies the name into the
// store byte by byte before it writes the new entry. The single read port of
// each ram sets this byte-wise pace. Uses stst_pkg, stst_symtab and stst_ram.
module source_tokenizer_symbol_table
    import stst_pkg::*;
#(
    parameter int TABLE_ENTRIES    = TABLE_ENTRIES_DEF,
    parameter int NAME_STORE_BYTES = NAME_STORE_BYTES_DEF,
    parameter int NAME_MAX         = NAME_MAX_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      src_valid,
    output logic      src_stall,
    input  src_word_t src_data,
    output logic      tok_valid,
    input  logic      tok_stall,
    output tok_word_t tok_data
);

    localparam int ENT_W = $clog2(TABLE_ENTRIES);
    localparam int NB_W  = $clog2(NAME_MAX);
    localparam int LEN_W = $clog2(NAME_MAX + 1);

    lex_state_t state_reg, state_next;
    lex_mode_t  mode_reg, mode_next;
    logic [7:0]        ch_reg;
    logic              eoi_reg;
    logic [LEN_W-1:0]  name_len_reg, name_len_next;
    logic [NUM_W-1:0]  number_reg, number_next;
    logic [LINE_W-1:0] line_reg, line_next;
    tok_word_t         res_reg, res_next;
    logic              fresh_reg, fresh_next;
    logic              out_valid_reg;
    tok_word_t         out_word_reg;

    sym_ctl_t          ctl;
    sym_rsp_t          rsp;
    logic [ENT_W-1:0]  sym_idx;
    logic [NB_W-1:0]   char_addr;

    logic              accept, out_free, load_out;
    logic              fresh_result, is_alnum;
    logic [3:0]        digit;
    logic [NUM_W+3:0]  scaled;
    logic [LINE_W-1:0] line_bump;

    assign accept    = src_valid && !src_stall;
    assign out_free  = !out_valid_reg || !tok_stall;
    assign digit     = ch_reg[3:0] - CH_ZERO[3:0];
    assign scaled    = ((NUM_W+4)'(number_reg) << 3) + ((NUM_W+4)'(number_reg) << 1)
                       + (NUM_W+4)'(digit);
    assign line_bump = (line_reg == LINE_MAX) ? line_reg : line_reg + LINE_W'(1);
    assign is_alnum  = is_alpha(ch_reg) || is_digit(ch_reg);
    // the byte handled fresh gives a token of its own
    assign fresh_result = eoi_reg || !(ch_reg == CH_SPACE || ch_reg == CH_TAB
        || ch_reg == CH_NEWLINE || ch_reg == CH_HASH || is_alnum);

    stst_symtab #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .NAME_STORE_BYTES(NAME_STORE_BYTES),
        .NAME_MAX(NAME_MAX)
    ) u_symtab (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .name_len(name_len_reg),
        .char_addr(char_addr), .name_char(ch_reg), .rsp(rsp), .idx(sym_idx)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LX_IDLE:
            begin
                if (accept)
                begin
                    state_next = LX_STEP;
                end
            end
            LX_STEP:
            begin
                case (mode_reg)
                    M_NUMBER:
                    begin
                        state_next = (!eoi_reg && is_digit(ch_reg)) ? LX_IDLE : LX_EMIT;
                    end
                    M_NAME:
                    begin
                        if (!eoi_reg && is_alnum)
                        begin
                            state_next = (name_len_reg + LEN_W'(1) == LEN_W'(NAME_MAX))
                                ? LX_EMIT : LX_IDLE;
                        end
                        else
                        begin
                            state_next = LX_LOOK;
                        end
                    end
                    M_COMMENT:
                    begin
                        state_next = eoi_reg ? LX_EMIT : LX_IDLE;
                    end
                    M_IDLE:
                    begin
                        state_next = LX_FRESH;
                    end
                    default:
                    begin
                        state_next = LX_IDLE;
                    end
                endcase
            end
            LX_FRESH:
            begin
                state_next = fresh_result ? LX_EMIT : LX_IDLE;
            end
            LX_LOOK:
            begin
                state_next = LX_WAIT;
            end
            LX_WAIT:
            begin
                if (rsp.done)
                begin
                    state_next = LX_EMIT;
                end
            end
            LX_EMIT:
            begin
                if (out_free)
                begin
                    state_next = fresh_reg ? LX_FRESH : LX_IDLE;
                end
            end
            default:
            begin
                state_next = LX_IDLE;
            end
        endcase
    end

    // lexer datapath and symbol table controls
    always_comb
    begin
        mode_next     = mode_reg;
        name_len_next = name_len_reg;
        number_next   = number_reg;
        line_next     = line_reg;
        res_next      = res_reg;
        fresh_next    = fresh_reg;
        ctl           = '0;
        char_addr     = name_len_reg[NB_W-1:0];
        load_out      = 1'b0;
        case (state_reg)
            LX_STEP:
            begin
                case (mode_reg)
                    M_NUMBER:
                    begin
                        if (!eoi_reg && is_digit(ch_reg))
                        begin
                            number_next = (scaled > (NUM_W+4)'(NUM_LIMIT))
                                ? NUM_LIMIT : scaled[NUM_W-1:0];
                        end
                        else
                        begin
                            res_next   = '{TOK_NUM, VALUE_W'(number_reg), line_reg,
                                           ERR_NONE, !fresh_result};
                            fresh_next = 1'b1;
                            mode_next  = M_IDLE;
                        end
                    end
                    M_NAME:
                    begin
                        if (!eoi_reg && is_alnum)
                        begin
                            ctl.char_we   = 1'b1;
                            name_len_next = name_len_reg + LEN_W'(1);
                            if (name_len_reg + LEN_W'(1) == LEN_W'(NAME_MAX))
                            begin
                                res_next   = '{TOK_NONE, VALUE_NONE, line_reg,
                                               ERR_NAME_LONG, 1'b1};
                                fresh_next = 1'b0;
                                mode_next  = M_HALT;
                            end
                        end
                    end
                    M_COMMENT:
                    begin
                        if (eoi_reg)
                        begin
                            res_next   = '{TOK_DONE, VALUE_NONE, line_reg, ERR_NONE, 1'b1};
                            fresh_next = 1'b0;
                            mode_next  = M_IDLE;
                        end
                        else if (ch_reg == CH_NEWLINE)
                        begin
                            line_next = line_bump;
                            mode_next = M_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            LX_FRESH:
            begin
                fresh_next = 1'b0;
                if (eoi_reg)
                begin
                    res_next = '{TOK_DONE, VALUE_NONE, line_reg, ERR_NONE, 1'b1};
                end
                else if (ch_reg == CH_NEWLINE)
                begin
                    line_next = line_bump;
                end
                else if (is_digit(ch_reg))
                begin
                    mode_next   = M_NUMBER;
                    number_next = NUM_W'(digit);
                end
                else if (is_alpha(ch_reg))
                begin
                    // first name byte goes to the start of the buffer
                    mode_next     = M_NAME;
                    ctl.char_we   = 1'b1;
                    char_addr     = '0;
                    name_len_next = LEN_W'(1);
                end
                else if (ch_reg == CH_HASH)
                begin
                    mode_next = M_COMMENT;
                end
                else if (fresh_result)
                begin
                    res_next = '{TOKEN_W'(ch_reg), VALUE_NONE, line_reg, ERR_NONE, 1'b1};
                end
            end
            LX_LOOK:
            begin
                ctl.lookup_go = 1'b1;
            end
            LX_WAIT:
            begin
                if (rsp.done)
                begin
                    if (rsp.err != ERR_NONE)
                    begin
                        res_next   = '{TOK_NONE, VALUE_NONE, line_reg, rsp.err, 1'b1};
                        fresh_next = 1'b0;
                        mode_next  = M_HALT;
                    end
                    else
                    begin
                        res_next   = '{rsp.token, VALUE_W'(sym_idx), line_reg,
                                       ERR_NONE, !fresh_result};
                        fresh_next = 1'b1;
                        mode_next  = M_IDLE;
                    end
                end
            end
            LX_EMIT:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= LX_IDLE;
            mode_reg      <= M_IDLE;
            name_len_reg  <= '0;
            number_reg    <= '0;
            line_reg      <= LINE_W'(1);
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            name_len_reg <= name_len_next;
            number_reg   <= number_next;
            line_reg     <= line_next;
            fresh_reg    <= fresh_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!tok_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // input capture, result staging and output word register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= src_data.ch;
            eoi_reg <= src_data.end_of_input;
        end
        res_reg <= res_next;
        if (load_out)
        begin
            out_word_reg <= res_reg;
        end
    end

    assign src_stall = !(state_reg == LX_IDLE && rsp.ready);
    assign tok_valid = out_valid_reg;
    assign tok_data  = out_word_reg;

    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.lookup_go |-> rsp.idle)
        else $error("lookup started while the symbol table was busy");

    a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == LX_WAIT && rsp.done && rsp.err != ERR_NONE) |=> mode_reg == M_HALT)
        else $error("symbol table error did not halt the lexer");

    a_halt_stays: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_HALT |=> mode_reg == M_HALT)
        else $error("lexer left the halted mode");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line count wrapped to zero");

endmodule

/* test/testbench.sv */
// self-checking testbench for source_tokenizer_symbol_table
// depends on stst_pkg and the block's RTL; holds its own lexer and symbol table predictor
`timescale 1ns / 100ps

module testbench;
    import stst_pkg::*;

    localparam int ENTRIES   = 128;
    localparam int STORE_MAX = 1024;
    localparam int NAME_LEN  = 128;
    localparam int DRAIN     = 2000;

    typedef struct {
        src_word_t w;
        bit        fast;
    } src_item_t;

    logic      clk;
    logic      rst_n;
    logic      src_valid;
    logic      src_stall;
    src_word_t src_data;
    logic      tok_valid;
    logic      tok_stall;
    tok_word_t tok_data;

    source_tokenizer_symbol_table u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok_data  (tok_data)
    );

    // pending characters and expected tokens
    src_item_t char_q[$];
    bit        cur_fast;
    tok_word_t token_q[$];
    tok_word_t step_tokens[$];
    int        chars_taken;
    int        tokens_seen;
    int        names_seen;
    int        errors;

    // lexer and symbol table shadow state
    lex_mode_t    mode;
    logic [7:0]   name_buf[NAME_LEN];
    int unsigned  name_len;
    int unsigned  num_val;
    int unsigned  line_no;
    int unsigned  entry_cnt;
    int unsigned  store_used;
    logic [8:0]   ent_tok[ENTRIES];
    int unsigned  ent_start[ENTRIES];
    int unsigned  ent_len[ENTRIES];
    logic [7:0]   store[STORE_MAX];

    string kw_names[KW_COUNT] = '{
        "div", "mod", "program", "infix", "postfix", "begin", "end",
        "input", "output", "CONST", "VAR", "integer", "real", "char",
        "boolean", "if", "then", "while", "do", "writeln", "else", "not"};
    string pool[12] = '{"x", "y1", "Alpha", "cnt", "z9z", "Q", "beginX",
        "ENDING", "a2b3", "foo", "Bar", "ifx"};

    function automatic bit digit_c(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_c(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    // preload the keyword entries as the block does after reset
    task automatic init_table();
        int k;
        int j;
        mode = M_IDLE;
        name_len = 0;
        num_val = 0;
        line_no = 1;
        entry_cnt = 0;
        store_used = 0;
        for (k = 0; k < STORE_MAX; k++) store[k] = 8'h00;
        for (k = 0; k < KW_COUNT; k++)
        begin
            for (j = 0; j < kw_names[k].len(); j++)
                store[store_used + j] = kw_names[k][j];
            entry_cnt++;
            ent_tok[entry_cnt] = KW_CODE[k];
            ent_start[entry_cnt] = store_used;
            ent_len[entry_cnt] = kw_names[k].len();
            store_used += kw_names[k].len() + 1;
        end
    endtask

    task automatic emit(input logic [8:0] t, input logic [31:0] v, input logic [1:0] e);
        tok_word_t r;
        r.token = t;
        r.token_value = v;
        r.line = line_no[15:0];
        r.error_kind = e;
        r.last_of_run = 1'b0;
        step_tokens.push_back(r);
    endtask

    task automatic next_line();
        if (line_no < 32'hFFFF) line_no++;
    endtask

    // returns 1 when the name has reached the length limit
    function automatic bit grow_name(input logic [7:0] c);
        if (name_len < NAME_LEN) name_buf[name_len] = c;
        name_len++;
        return name_len >= NAME_LEN;
    endfunction

    // newest-first lookup, insert on a miss; returns the error kind
    function automatic logic [1:0] resolve_name(output int unsigned idx);
        int unsigned p;
        int unsigned k;
        bit same;
        idx = 0;
        for (p = entry_cnt; p > 0; p--)
        begin
            if (p < ENTRIES && ent_len[p] == name_len)
            begin
                same = 1;
                for (k = 0; k < name_len; k++)
                    if (store[ent_start[p] + k] != name_buf[k]) same = 0;
                if (same)
                begin
                    idx = p;
                    return ERR_NONE;
                end
            end
        end
        if (entry_cnt + 1 >= ENTRIES) return ERR_TABLE_FULL;
        if (store_used + name_len >= STORE_MAX) return ERR_STORE_FULL;
        entry_cnt++;
        ent_tok[entry_cnt] = TOK_ID;
        ent_start[entry_cnt] = store_used;
        ent_len[entry_cnt] = name_len;
        for (k = 0; k < name_len; k++) store[store_used + k] = name_buf[k];
        store[store_used + name_len] = 8'h00;
        store_used += name_len + 1;
        idx = entry_cnt;
        return ERR_NONE;
    endfunction

    // idle-state handling of a fresh character
    task automatic fresh_char(input logic [7:0] c, input bit eoi);
        if (eoi)
            emit(TOK_DONE, VALUE_NONE, ERR_NONE);
        else if (c == CH_SPACE || c == CH_TAB)
            ;
        else if (c == CH_NEWLINE)
            next_line();
        else if (digit_c(c))
        begin
            mode = M_NUMBER;
            num_val = c - CH_ZERO;
        end
        else if (letter_c(c))
        begin
            mode = M_NAME;
            name_len = 0;
            if (grow_name(c))
            begin
                emit(TOK_NONE, VALUE_NONE, ERR_NAME_LONG);
                mode = M_HALT;
            end
        end
        else if (c == CH_HASH)
            mode = M_COMMENT;
        else
            emit({1'b0, c}, VALUE_NONE, ERR_NONE);
    endtask

    // work out the tokens caused by one accepted character word
    task automatic lex_char(input src_word_t w);
        logic [7:0] c;
        bit eoi;
        bit fresh;
        int unsigned d;
        int unsigned idx;
        logic [1:0] e;
        c = w.ch;
        eoi = w.end_of_input;
        fresh = 1;
        step_tokens.delete();
        case (mode)
            M_HALT: fresh = 0;
            M_NUMBER:
            begin
                if (!eoi && digit_c(c))
                begin
                    d = c - CH_ZERO;
                    if (num_val > (32'h7FFF_FFFF - d) / 10) num_val = 32'h7FFF_FFFF;
                    else num_val = num_val * 10 + d;
                    fresh = 0;
                end
                else
                begin
                    emit(TOK_NUM, num_val, ERR_NONE);
                    mode = M_IDLE;
                end
            end
            M_NAME:
            begin
                if (!eoi && (letter_c(c) || digit_c(c)))
                begin
                    if (grow_name(c))
                    begin
                        emit(TOK_NONE, VALUE_NONE, ERR_NAME_LONG);
                        mode = M_HALT;
                    end
                    fresh = 0;
                end
                else
                begin
                    e = resolve_name(idx);
                    if (e != ERR_NONE)
                    begin
                        emit(TOK_NONE, VALUE_NONE, e);
                        mode = M_HALT;
                        fresh = 0;
                    end
                    else
                    begin
                        emit(ent_tok[idx], idx, ERR_NONE);
                        mode = M_IDLE;
                    end
                end
            end
            M_COMMENT:
            begin
                fresh = 0;
                if (eoi)
                begin
                    emit(TOK_DONE, VALUE_NONE, ERR_NONE);
                    mode = M_IDLE;
                end
                else if (c == CH_NEWLINE)
                begin
                    next_line();
                    mode = M_IDLE;
                end
            end
            default: ;
        endcase
        if (fresh) fresh_char(c, eoi);
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
        foreach (step_tokens[i]) token_q.push_back(step_tokens[i]);
    endtask

    // stimulus helpers
    task automatic put_char(input logic [7:0] c, input bit eoi = 0, input bit fast = 0);
        src_item_t it;
        it.w.ch = c;
        it.w.end_of_input = eoi;
        it.fast = fast;
        char_q.push_back(it);
    endtask

    task automatic put_text(input string s);
        foreach (s[i]) put_char(s[i]);
    endtask

    // letter number r of a-z followed by A-Z
    function automatic logic [7:0] letter_at(input int r);
        if (r < 26) return 8'("a" + r);
        return 8'("A" + r - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        if (r < 52) return letter_at(r);
        return 8'("0" + r - 52);
    endfunction

    function automatic logic [7:0] rand_punct();
        logic [7:0] c;
        do c = $urandom_range(0, 255);
        while (digit_c(c) || letter_c(c) || c == CH_SPACE || c == CH_TAB ||
               c == CH_NEWLINE || c == CH_HASH);
        return c;
    endfunction

    function automatic logic [7:0] rand_sep();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_NEWLINE;
            default: return rand_punct();
        endcase
    endfunction

    // one lexeme-like chunk of random source text
    task automatic put_random_chunk();
        int n;
        int k;
        case ($urandom_range(0, 9))
            0, 1: put_text(kw_names[$urandom_range(0, KW_COUNT - 1)]);
            2, 3: put_text(pool[$urandom_range(0, 11)]);
            4:
            begin
                put_char(letter_at($urandom_range(0, 25)));
                n = $urandom_range(0, 6);
                for (k = 0; k < n; k++) put_char(rand_alnum());
            end
            5:
            begin
                n = $urandom_range(1, 13);
                for (k = 0; k < n; k++) put_char(8'("0" + $urandom_range(0, 9)));
            end
            6:
            begin
                put_char(CH_HASH);
                n = $urandom_range(0, 5);
                for (k = 0; k < n; k++) put_char(8'($urandom_range(0, 255)));
                put_char(CH_NEWLINE);
            end
            7: put_char(rand_punct());
            8: put_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            default: put_char(8'($urandom_range(0, 255)), 1);
        endcase
        if ($urandom_range(0, 2) != 0) put_char(rand_sep());
    endtask

    // idle and stall rates per traffic phase
    function automatic int traffic_phase();
        if (cur_fast) return 0;
        return (chars_taken / 60) % 4;
    endfunction

    function automatic int send_idle_pct();
        case (traffic_phase())
            1: return 72;
            3: return 17;
            default: return 0;
        endcase
    endfunction

    function automatic int recv_stall_pct();
        case (traffic_phase())
            2: return 72;
            3: return 17;
            default: return 0;
        endcase
    endfunction

    // clock and reset
    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // character driver; predicts on each accepted word
    always @(posedge clk or negedge rst_n)
    begin
        src_item_t it;
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_data  <= '0;
        end
        else
        begin
            if (src_valid && !src_stall)
            begin
                lex_char(src_data);
                chars_taken++;
            end
            if (!src_valid || !src_stall)
            begin
                if (char_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct())
                begin
                    it = char_q.pop_front();
                    cur_fast = it.fast;
                    src_valid <= 1'b1;
                    src_data  <= it.w;
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    // token monitor and receiver stall
    always @(posedge clk or negedge rst_n)
    begin
        tok_word_t want;
        if (!rst_n)
            tok_stall <= 1'b0;
        else
        begin
            if (tok_valid && !tok_stall)
            begin
                tokens_seen++;
                if (token_q.size() == 0)
                begin
                    $error("unexpected token word %h", tok_data);
                    errors++;
                end
                else
                begin
                    want = token_q.pop_front();
                    if (want.token >= 257 && want.token != TOK_DONE) names_seen++;
                    if (tok_data.token !== want.token)
                    begin
                        $error("token: expected %0d, got %0d", want.token, tok_data.token);
                        errors++;
                    end
                    if (tok_data.token_value !== want.token_value)
                    begin
                        $error("token_value: expected %0d, got %0d",
                               want.token_value, tok_data.token_value);
                        errors++;
                    end
                    if (tok_data.line !== want.line)
                    begin
                        $error("line: expected %0d, got %0d", want.line, tok_data.line);
                        errors++;
                    end
                    if (tok_data.error_kind !== want.error_kind)
                    begin
                        $error("error_kind: expected %0d, got %0d",
                               want.error_kind, tok_data.error_kind);
                        errors++;
                    end
                    if (tok_data.last_of_run !== want.last_of_run)
                    begin
                        $error("last_of_run: expected %0d, got %0d",
                               want.last_of_run, tok_data.last_of_run);
                        errors++;
                    end
                end
            end
            tok_stall <= ($urandom_range(0, 99) < recv_stall_pct());
        end
    end

    // run limit
    initial
    begin
        #40ms;
        $display("timeout with %0d tokens still expected", token_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

    // stimulus and end of run
    initial
    begin
        int k;
        int ending;
        int fill_to;
        chars_taken = 0;
        tokens_seen = 0;
        names_seen = 0;
        errors = 0;
        cur_fast = 0;
        init_table();

        // pick the halting error first so the run stays near its word budget
        ending = $urandom_range(0, 1);
        fill_to = (ending == 0) ? 310 : 130;

        // directed: keywords, case, number extremes, glued tokens, comments, end
        put_text("div CONST Const 0 2147483647 99999999999x\t");
        put_text("a1Z9(12ab");
        put_char(8'h00);
        put_char(8'hFF);
        put_text("#c\n");
        put_text("not;# tail");
        put_char(8'h55, 1);
        put_text("5");
        put_char(8'hAA, 1);

        // random source text, mostly well-formed
        while (char_q.size() < fill_to) put_random_chunk();

        // finish with one of the halting errors, then words that give nothing
        if (ending == 0)
        begin
            put_char("L");
            for (k = 0; k < NAME_LEN - 1; k++) put_char(rand_alnum());
        end
        else
        begin
            // short distinct names until the table runs out of entries
            for (k = 0; k < 110; k++)
            begin
                put_char((k < 52) ? "W" : (k < 104) ? "X" : "Z");
                put_char(letter_at(k % 52));
                put_char(CH_SPACE);
            end
        end
        put_text("7 q+");
        put_char(8'h00, 1);

        while (char_q.size() > 0 || src_valid !== 1'b0) @(posedge clk);
        while (token_q.size() > 0) @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (token_q.size() > 0) errors++;
        $display("%0d characters fed, %0d tokens checked (%0d names/keywords), halt kind %0d",
                 chars_taken, tokens_seen, names_seen, ending + 1);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* filelist.f */
src/stst_pkg.sv
src/stst_ram.sv
src/stst_symtab.sv
src/source_tokenizer_symbol_table.sv
test/testbench.sv
